// ===== src/fs_group_base_meta_clusters_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef FS_GROUP_BASE_META_CLUSTERS_ASSERT_SVH
`define FS_GROUP_BASE_META_CLUSTERS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FSGBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsgbm assertion failed");

// Next-cycle implication, checked outside reset.
`define FSGBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsgbm assertion failed");

`endif

// ===== src/fsgbm_pkg.sv =====
package fsgbm_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARSE_SUPER_ON      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_META_BG_ON           = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_META_GROUP     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DESC_PER_BLOCK_LOG2  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_DESC_BLOCK_COUNT     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RESERVED_DESC_BLOCKS = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLUSTER_SHIFT        = 3'd6;

    // Register reset values
    localparam logic        RST_SPARSE_SUPER_ON      = 1'b1;
    localparam logic        RST_META_BG_ON           = 1'b0;
    localparam logic [31:0] RST_FIRST_META_GROUP     = 32'd0;
    localparam logic [3:0]  RST_DESC_PER_BLOCK_LOG2  = 4'd7;
    localparam logic [31:0] RST_DESC_BLOCK_COUNT     = 32'd1;
    localparam logic [15:0] RST_RESERVED_DESC_BLOCKS = 16'd0;
    localparam logic [3:0]  RST_CLUSTER_SHIFT        = 4'd0;

    // Widths of the stream payloads
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 72;
    localparam int unsigned CFG_DATA_W = 32;

    // Bases of the superblock backup power test
    localparam logic [2:0] BASE_7 = 3'd7;
    localparam logic [2:0] BASE_5 = 3'd5;
    localparam logic [2:0] BASE_3 = 3'd3;

    // Control between the sequencer and the power test unit
    typedef struct packed {
        logic start;
    } t_pow_req;

    typedef struct packed {
        logic done;
        logic found;
    } t_pow_rsp;

endpackage

// ===== src/fsgbm_pow.sv =====
module fsgbm_pow #(
    parameter int GROUP_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  fsgbm_pkg::t_pow_req     i_req,
    input  logic [GROUP_BITS-1:0]   i_group,
    output fsgbm_pkg::t_pow_rsp     o_rsp
);
    import fsgbm_pkg::*;

    // Running power needs room for one step past the group value
    localparam int PW = GROUP_BITS + 3;

    typedef enum logic [3:0] {
        PS_IDLE = 4'b0001,
        PS_B7   = 4'b0010,
        PS_B5   = 4'b0100,
        PS_B3   = 4'b1000
    } t_pow_state;

    t_pow_state      r_state, n_state;
    logic [PW-1:0]   r_p, n_p;
    logic [2:0]      w_base;
    logic [PW-1:0]   w_prod;
    logic [PW-1:0]   w_g;

    // Select the base of the current pass
    always_comb begin
        unique case (r_state)
            PS_B7:   w_base = BASE_7;
            PS_B5:   w_base = BASE_5;
            PS_B3:   w_base = BASE_3;
            default: w_base = BASE_3;
        endcase
    end

    // Shared multiplier: running power times base
    assign w_prod = r_p * PW'(w_base);
    assign w_g    = PW'(i_group);

    // Step the power until it reaches or passes the group; stop on a match, else try the next base
    always_comb begin
        n_state     = r_state;
        n_p         = r_p;
        o_rsp.done  = 1'b0;
        o_rsp.found = 1'b0;
        unique case (r_state)
            PS_IDLE: begin
                if (i_req.start) begin
                    n_state = PS_B7;
                    n_p     = PW'(BASE_7);
                end
            end
            PS_B7, PS_B5, PS_B3: begin
                if (w_g > r_p) begin
                    n_p = w_prod;
                end else if (w_g == r_p) begin
                    o_rsp.done  = 1'b1;
                    o_rsp.found = 1'b1;
                    n_state     = PS_IDLE;
                end else if (r_state == PS_B3) begin
                    o_rsp.done = 1'b1;
                    n_state    = PS_IDLE;
                end else if (r_state == PS_B7) begin
                    n_state = PS_B5;
                    n_p     = PW'(BASE_5);
                end else begin
                    n_state = PS_B3;
                    n_p     = PW'(BASE_3);
                end
            end
            default: n_state = PS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_p <= n_p;
    end

endmodule

// ===== src/fs_group_base_meta_clusters.sv =====
// Path: an input transfer goes to the calc state and then loads the output register when no
// power test runs (sparse mode off, group 0 or 1, or an even group); otherwise via the power test.
// Power test: one multiply step a cycle, bases 7, 5 and 3 in turn, stopping on a hit;
// the steps run one after another, set by the single shared multiplier.
// Flow: a new item is taken only once the last is in the output register; a stall delays that.
// Reset: synchronous, active low; restores register defaults and empties the output.
module fs_group_base_meta_clusters #(
    parameter int GROUP_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [fsgbm_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [fsgbm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fsgbm_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [31:0] group
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] has_super_backup, [32:1] desc_blocks, [64:33] meta_clusters, [71:65] zero
    output logic [fsgbm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import fsgbm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POW  = 3'b010,
        ST_CALC = 3'b100
    } t_state;

    // Configuration registers
    logic                  r_sparse_on;
    logic                  r_meta_bg_on;
    logic [31:0]           r_first_meta_group;
    logic [3:0]            r_dpb_log2;
    logic [31:0]           r_desc_block_count;
    logic [15:0]           r_reserved_desc;
    logic [3:0]            r_cluster_shift;

    t_state                r_state, n_state;
    logic [GROUP_BITS-1:0] r_group, n_group;
    logic                  r_has, n_has;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_has, n_out_has;
    logic [31:0]           r_out_desc, n_out_desc;
    logic [31:0]           r_out_clus, n_out_clus;

    t_pow_req              w_pow_req;
    t_pow_rsp              w_pow_rsp;

    logic [GROUP_BITS-1:0] w_in_group;
    logic                  w_in_above_one;
    logic                  w_in_xfer;
    logic                  w_out_free;
    logic [GROUP_BITS-1:0] w_gshift;
    logic [31:0]           w_mask;
    logic [31:0]           w_off;
    logic                  w_below;
    logic                  w_edge;
    logic [31:0]           w_desc;
    logic [33:0]           w_blocks;
    logic [34:0]           w_round;
    logic [34:0]           w_clus;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sparse_on        <= RST_SPARSE_SUPER_ON;
            r_meta_bg_on       <= RST_META_BG_ON;
            r_first_meta_group <= RST_FIRST_META_GROUP;
            r_dpb_log2         <= RST_DESC_PER_BLOCK_LOG2;
            r_desc_block_count <= RST_DESC_BLOCK_COUNT;
            r_reserved_desc    <= RST_RESERVED_DESC_BLOCKS;
            r_cluster_shift    <= RST_CLUSTER_SHIFT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SPARSE_SUPER_ON:      r_sparse_on        <= i_cfg_wdata[0];
                CFG_META_BG_ON:           r_meta_bg_on       <= i_cfg_wdata[0];
                CFG_FIRST_META_GROUP:     r_first_meta_group <= i_cfg_wdata;
                CFG_DESC_PER_BLOCK_LOG2:  r_dpb_log2         <= i_cfg_wdata[3:0];
                CFG_DESC_BLOCK_COUNT:     r_desc_block_count <= i_cfg_wdata;
                CFG_RESERVED_DESC_BLOCKS: r_reserved_desc    <= i_cfg_wdata[15:0];
                CFG_CLUSTER_SHIFT:        r_cluster_shift    <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Shared power test unit
    fsgbm_pow #(
        .GROUP_BITS (GROUP_BITS)
    ) u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_pow_req),
        .i_group (r_group),
        .o_rsp   (w_pow_rsp)
    );

    assign s_axis_tready  = (r_state == ST_IDLE);
    assign w_in_xfer      = s_axis_tvalid && s_axis_tready;
    assign w_in_group     = s_axis_tdata[GROUP_BITS-1:0];
    assign w_in_above_one = |w_in_group[GROUP_BITS-1:1];
    assign w_out_free     = !r_out_valid || m_axis_tready;

    // Boundary test: meta group index against first meta group, at full width
    assign w_gshift = r_group >> r_dpb_log2;
    assign w_below  = !r_meta_bg_on || (32'(w_gshift) < r_first_meta_group);

    // Position inside the meta group: first, second or last
    assign w_mask = ~(32'hFFFF_FFFF << r_dpb_log2);
    assign w_off  = 32'(r_group) & w_mask;
    assign w_edge = (w_off == '0) || (w_off == 32'd1) || (w_off == w_mask);

    // Count descriptor and total blocks
    always_comb begin
        if (w_below) begin
            if (r_has) begin
                w_desc   = r_meta_bg_on ? r_first_meta_group : r_desc_block_count;
                w_blocks = 34'(1) + 34'(w_desc) + 34'(r_reserved_desc);
            end else begin
                w_desc   = '0;
                w_blocks = '0;
            end
        end else begin
            w_desc   = 32'(w_edge);
            w_blocks = 34'(r_has) + 34'(w_edge);
        end
    end

    // Round up to clusters
    assign w_round = 35'(w_blocks) + ((35'(1) << r_cluster_shift) - 35'(1));
    assign w_clus  = w_round >> r_cluster_shift;

    // Sequence one item: take it, run the power test if needed, load the result
    always_comb begin
        n_state         = r_state;
        n_group         = r_group;
        n_has           = r_has;
        n_out_valid     = r_out_valid && !m_axis_tready;
        n_out_has       = r_out_has;
        n_out_desc      = r_out_desc;
        n_out_clus      = r_out_clus;
        w_pow_req.start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_group = w_in_group;
                    if (r_sparse_on && w_in_above_one && w_in_group[0]) begin
                        w_pow_req.start = 1'b1;
                        n_state         = ST_POW;
                    end else begin
                        n_has   = !r_sparse_on || !w_in_above_one;
                        n_state = ST_CALC;
                    end
                end
            end
            ST_POW: begin
                if (w_pow_rsp.done) begin
                    n_has   = w_pow_rsp.found;
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_has   = r_has;
                    n_out_desc  = w_desc;
                    n_out_clus  = (|w_clus[34:32]) ? 32'hFFFF_FFFF : w_clus[31:0];
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_group    <= n_group;
        r_has      <= n_has;
        r_out_has  <= n_out_has;
        r_out_desc <= n_out_desc;
        r_out_clus <= n_out_clus;
    end

    // Drive the output stream
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_clus, r_out_desc, r_out_has});

endmodule

// ===== src/fsgbm_checker.sv =====
module fsgbm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [fsgbm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
`include "fs_group_base_meta_clusters_assert.svh"

    // A stalled result holds its value
    `FSGBM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // One item at a time: input closes right after a transfer
    `FSGBM_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // Padding above the cluster count stays zero
    `FSGBM_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[71:65] == 7'd0)

    // Cluster count is zero exactly when nothing is counted
    `FSGBM_ASSERT_NOW(a_clus_zero, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[64:33] == 32'd0) == (!m_axis_tdata[0] && m_axis_tdata[32:1] == 32'd0))

endmodule

bind fs_group_base_meta_clusters fsgbm_checker u_fsgbm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
